// File: rtl/gjk_intersection_step_core_macros.svh
// Assertion macros used by the port-level checker of the GJK step core.
`ifndef GJK_INTERSECTION_STEP_CORE_MACROS_SVH
`define GJK_INTERSECTION_STEP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define GJKIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gjkis check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define GJKIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gjkis check failed");

`endif

// File: rtl/gjkis_pkg.sv
// Types, constants and helper functions of the GJK intersection step core.
package gjkis_pkg;

  localparam int COORD_BITS = 12;
  localparam int PT_W       = 12;
  localparam int NW         = COORD_BITS + 2;
  localparam int DIR_W      = 42;
  localparam int PROD_W     = DIR_W + NW;
  localparam int ACC_W      = PROD_W + 2;
  localparam int IT_W       = 6;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [IT_W-1:0] MAX_ITER_RESET = IT_W'(32);
  localparam logic            REG_MAX_ITER   = 1'b0;
  localparam logic            FUNC_START     = 1'b0;

  typedef logic signed [NW-1:0] ncomp_t;
  typedef logic [2:0][NW-1:0]    nvec_t;
  typedef logic [2:0][DIR_W-1:0] dvec_t;

  typedef enum logic [1:0] {
    STAT_QUERY   = 2'd0,
    STAT_SEP     = 2'd1,
    STAT_HIT     = 2'd2,
    STAT_IDLE_PT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_LOOP   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    W_DIR, W_W0, W_W1, W_W2, W_AB, W_AC, W_AD
  } wsel_t;

  typedef enum logic [2:0] {
    N_A, N_AB, N_AC, N_AD, N_AO
  } nsel_t;

  typedef enum logic [1:0] {
    D_W0, D_W1, D_W2, D_DIR
  } dst_t;

  // One operation of the shared multiply-accumulate unit.
  typedef struct packed {
    logic  is_dot;
    wsel_t wsel;
    nsel_t nsel;
    logic  neg;
    dst_t  dst;
  } op_t;

  function automatic ncomp_t sext_pt(input logic [PT_W-1:0] v);
    logic signed [COORD_BITS-1:0] t;
    t = v[COORD_BITS-1:0];
    return NW'(t);
  endfunction

  function automatic dvec_t widen(input nvec_t v);
    dvec_t r;
    for (int k = 0; k < 3; k++) begin
      r[k] = DIR_W'($signed(v[k]));
    end
    return r;
  endfunction

  function automatic dvec_t neg_d(input dvec_t v);
    dvec_t r;
    for (int k = 0; k < 3; k++) begin
      r[k] = DIR_W'(-$signed(v[k]));
    end
    return r;
  endfunction

  // Component index (i + k) mod 3.
  function automatic logic [1:0] rot(input logic [1:0] i, input logic [1:0] k);
    logic [2:0] s;
    s = {1'b0, i} + {1'b0, k};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

endpackage

// File: rtl/gjk_intersection_step_core.sv
// Top level of the GJK intersection step core with its shared multiply-accumulate unit.
//
// Channel   Direction  Handshake            Payload
// in        to core    in_valid / in_ready  func, pt_x, pt_y, pt_z
// out       from core  out_valid / out_ready status, dir_x, dir_y, dir_z
// cfg       to core    APB psel / penable   max_iterations at byte address 0
//
// A start item, a point while idle and the first point need no products.
// A later point runs dot and cross products, and every product goes one at a
// time through a single 42 x 14 bit multiplier followed by one accumulator.
// Reset is synchronous; no item is taken while a point is being worked on.
// A finished result waits in the output register while the next item is taken;
// while that register is still full the core stalls before it becomes ready.
module gjk_intersection_step_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic signed [gjkis_pkg::PT_W-1:0] pt_x,
  input  logic signed [gjkis_pkg::PT_W-1:0] pt_y,
  input  logic signed [gjkis_pkg::PT_W-1:0] pt_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [gjkis_pkg::DIR_W-1:0] dir_x,
  output logic signed [gjkis_pkg::DIR_W-1:0] dir_y,
  output logic signed [gjkis_pkg::DIR_W-1:0] dir_z,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gjkis_pkg::ADDR_W-1:0]      paddr,
  input  logic [gjkis_pkg::DATA_W-1:0]      pwdata,
  output logic [gjkis_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  typedef enum logic [23:0] {
    ST_IDLE = 24'h000001,
    ST_PUT  = 24'h000002,
    S2_DOT  = 24'h000004,
    S2_C1   = 24'h000008,
    S2_C2   = 24'h000010,
    S2_FIX  = 24'h000020,
    L_DOT   = 24'h000040,
    T_NRM   = 24'h000080,
    T_C1    = 24'h000100,
    T_D1    = 24'h000200,
    T_C2    = 24'h000400,
    T_C3    = 24'h000800,
    T_C4    = 24'h001000,
    T_D2    = 24'h002000,
    T_C5    = 24'h004000,
    T_C6    = 24'h008000,
    T_D3    = 24'h010000,
    Q_F1    = 24'h020000,
    Q_D1    = 24'h040000,
    Q_F2    = 24'h080000,
    Q_D2    = 24'h100000,
    Q_F3    = 24'h200000,
    Q_D3    = 24'h400000,
    ST_FIN  = 24'h800000
  } state_t;

  state_t                          state;
  gjkis_pkg::phase_t               phase;
  gjkis_pkg::status_t              res_status;
  logic [gjkis_pkg::IT_W-1:0]      iter;
  logic [gjkis_pkg::IT_W-1:0]      max_it;
  logic                            size3;
  logic [2:0]                      cnt;

  gjkis_pkg::nvec_t pa, pb, pc, pd, vab, vac, vad, vao;
  gjkis_pkg::dvec_t w0, w1, w2, sdir;

  logic signed [gjkis_pkg::PROD_W-1:0] prod_q;
  logic signed [gjkis_pkg::ACC_W-1:0]  acc;

  gjkis_pkg::op_t   op;
  logic             is_op;
  logic [2:0]       last_cnt;
  logic             op_done;
  logic [1:0]       comp_i, wi, ni;
  logic [2:0]       jj;
  gjkis_pkg::dvec_t wvec;
  gjkis_pkg::nvec_t nvec;
  logic signed [gjkis_pkg::DIR_W-1:0]  wop;
  logic signed [gjkis_pkg::NW-1:0]     nop;
  logic signed [gjkis_pkg::ACC_W-1:0]  acc_base, acc_sum;
  logic                                first_term, sub_term, eng_wr;
  logic [1:0]                          wcomp;
  logic [gjkis_pkg::DIR_W-1:0]         dval;
  logic                                dot_neg, dot_pos;

  logic                            accept, put_load, cfg_wr;
  gjkis_pkg::nvec_t                p_in, dab, dac, dad, dao;
  logic [gjkis_pkg::IT_W-1:0]      iter_inc;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign put_load = (state == ST_PUT) && (!out_valid || out_ready);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite &&
                    (paddr[gjkis_pkg::ADDR_W-1:2] == gjkis_pkg::REG_MAX_ITER);
  assign prdata   = (paddr[gjkis_pkg::ADDR_W-1:2] == gjkis_pkg::REG_MAX_ITER) ?
                    gjkis_pkg::DATA_W'(max_it) : '0;

  assign p_in[0] = gjkis_pkg::sext_pt(pt_x);
  assign p_in[1] = gjkis_pkg::sext_pt(pt_y);
  assign p_in[2] = gjkis_pkg::sext_pt(pt_z);

  // Edge vectors from the new point; on the second point the line edge is c - p.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dab[k] = (phase == gjkis_pkg::PH_SECOND) ?
               gjkis_pkg::NW'($signed(pc[k]) - $signed(p_in[k])) :
               gjkis_pkg::NW'($signed(pb[k]) - $signed(p_in[k]));
      dac[k] = gjkis_pkg::NW'($signed(pc[k]) - $signed(p_in[k]));
      dad[k] = gjkis_pkg::NW'($signed(pd[k]) - $signed(p_in[k]));
      dao[k] = gjkis_pkg::NW'(-$signed(p_in[k]));
    end
  end

  // Operation run by the shared unit in each working state.
  always_comb begin
    op    = '{is_dot: 1'b1, wsel: gjkis_pkg::W_DIR, nsel: gjkis_pkg::N_A,
              neg: 1'b0, dst: gjkis_pkg::D_W0};
    is_op = 1'b1;
    case (state)
      S2_DOT, L_DOT: begin
        op.wsel = gjkis_pkg::W_DIR; op.nsel = gjkis_pkg::N_A;
      end
      S2_C1: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_AB; op.nsel = gjkis_pkg::N_AO;
        op.dst = gjkis_pkg::D_W0;
      end
      S2_C2: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_W0; op.nsel = gjkis_pkg::N_AB;
        op.dst = gjkis_pkg::D_DIR;
      end
      T_NRM, Q_F1: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_AB; op.nsel = gjkis_pkg::N_AC;
        op.dst = gjkis_pkg::D_W0;
      end
      T_C1: begin
        // ab x nrm is the negation of nrm x ab.
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_W0; op.nsel = gjkis_pkg::N_AB;
        op.neg = 1'b1; op.dst = gjkis_pkg::D_W1;
      end
      T_D1, T_D2: begin
        op.wsel = gjkis_pkg::W_W1; op.nsel = gjkis_pkg::N_AO;
      end
      T_C2: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_AB; op.nsel = gjkis_pkg::N_AO;
        op.dst = gjkis_pkg::D_W2;
      end
      T_C3: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_W2; op.nsel = gjkis_pkg::N_AB;
        op.dst = gjkis_pkg::D_DIR;
      end
      T_C4: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_W0; op.nsel = gjkis_pkg::N_AC;
        op.dst = gjkis_pkg::D_W1;
      end
      T_C5: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_AC; op.nsel = gjkis_pkg::N_AO;
        op.dst = gjkis_pkg::D_W2;
      end
      T_C6: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_W2; op.nsel = gjkis_pkg::N_AC;
        op.dst = gjkis_pkg::D_DIR;
      end
      T_D3, Q_D1, Q_D2, Q_D3: begin
        op.wsel = gjkis_pkg::W_W0; op.nsel = gjkis_pkg::N_AO;
      end
      Q_F2: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_AC; op.nsel = gjkis_pkg::N_AD;
        op.dst = gjkis_pkg::D_W0;
      end
      Q_F3: begin
        op.is_dot = 1'b0; op.wsel = gjkis_pkg::W_AD; op.nsel = gjkis_pkg::N_AB;
        op.dst = gjkis_pkg::D_W0;
      end
      default: is_op = 1'b0;
    endcase
  end

  assign last_cnt = op.is_dot ? 3'd3 : 3'd6;
  assign op_done  = is_op && (cnt == last_cnt);

  // Issue side: product number cnt, two per cross component, one per dot term.
  assign comp_i = op.is_dot ? cnt[1:0] : cnt[2:1];
  assign wi = op.is_dot ? comp_i : gjkis_pkg::rot(comp_i, cnt[0] ? 2'd2 : 2'd1);
  assign ni = op.is_dot ? comp_i : gjkis_pkg::rot(comp_i, cnt[0] ? 2'd1 : 2'd2);

  always_comb begin
    case (op.wsel)
      gjkis_pkg::W_DIR: wvec = sdir;
      gjkis_pkg::W_W0:  wvec = w0;
      gjkis_pkg::W_W1:  wvec = w1;
      gjkis_pkg::W_W2:  wvec = w2;
      gjkis_pkg::W_AB:  wvec = gjkis_pkg::widen(vab);
      gjkis_pkg::W_AC:  wvec = gjkis_pkg::widen(vac);
      gjkis_pkg::W_AD:  wvec = gjkis_pkg::widen(vad);
      default:          wvec = sdir;
    endcase
    case (op.nsel)
      gjkis_pkg::N_A:  nvec = pa;
      gjkis_pkg::N_AB: nvec = vab;
      gjkis_pkg::N_AC: nvec = vac;
      gjkis_pkg::N_AD: nvec = vad;
      gjkis_pkg::N_AO: nvec = vao;
      default:         nvec = pa;
    endcase
  end

  assign wop = $signed(wvec[wi]);
  assign nop = $signed(nvec[ni]);

  // Accumulate side: works on the product issued in the previous cycle.
  assign jj         = cnt - 3'd1;
  assign first_term = op.is_dot ? (jj == 3'd0) : !jj[0];
  assign sub_term   = !op.is_dot && jj[0];
  assign acc_base   = first_term ? '0 : acc;
  assign acc_sum    = sub_term ? acc_base - gjkis_pkg::ACC_W'(prod_q) :
                                 acc_base + gjkis_pkg::ACC_W'(prod_q);
  assign eng_wr     = is_op && !op.is_dot && (cnt != 3'd0) && jj[0];
  assign wcomp      = jj[2:1];
  assign dval       = gjkis_pkg::DIR_W'(op.neg ? -acc_sum : acc_sum);
  assign dot_neg    = acc_sum[gjkis_pkg::ACC_W-1];
  assign dot_pos    = !dot_neg && (acc_sum != '0);
  assign iter_inc   = iter + 1'b1;

  always_ff @(posedge clk) begin
    prod_q <= wop * nop;
    if (is_op && cnt != 3'd0) begin
      acc <= acc_sum;
    end
    if (eng_wr) begin
      case (op.dst)
        gjkis_pkg::D_W0:  w0[wcomp]   <= dval;
        gjkis_pkg::D_W1:  w1[wcomp]   <= dval;
        gjkis_pkg::D_W2:  w2[wcomp]   <= dval;
        gjkis_pkg::D_DIR: sdir[wcomp] <= dval;
        default:          w0[wcomp]   <= dval;
      endcase
    end
    if (accept && func != gjkis_pkg::FUNC_START &&
        (phase == gjkis_pkg::PH_SECOND || phase == gjkis_pkg::PH_LOOP)) begin
      pa  <= p_in;
      vab <= dab;
      vac <= dac;
      vad <= dad;
      vao <= dao;
    end
    if (put_load) begin
      status <= res_status;
      if (res_status == gjkis_pkg::STAT_QUERY) begin
        dir_x <= sdir[0];
        dir_y <= sdir[1];
        dir_z <= sdir[2];
      end else begin
        dir_x <= '0;
        dir_y <= '0;
        dir_z <= '0;
      end
    end
    if (rst) begin
      pb   <= '0;
      pc   <= '0;
      pd   <= '0;
      sdir <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (func == gjkis_pkg::FUNC_START) begin
              sdir <= gjkis_pkg::widen(p_in);
            end else if (phase == gjkis_pkg::PH_FIRST) begin
              pc   <= p_in;
              sdir <= gjkis_pkg::neg_d(gjkis_pkg::widen(p_in));
            end else if (phase == gjkis_pkg::PH_SECOND) begin
              pb <= p_in;
            end
          end
        end
        S2_FIX: begin
          // The origin lies on the line: take a direction normal to the edge.
          if (sdir == '0) begin
            sdir[0] <= '0;
            sdir[2] <= '0;
            if (vab[1] == '0 && vab[2] == '0) begin
              sdir[1] <= gjkis_pkg::DIR_W'($signed(vab[0]));
            end else begin
              sdir[1] <= gjkis_pkg::DIR_W'($signed(vab[2]));
              sdir[2] <= gjkis_pkg::DIR_W'(-$signed(vab[1]));
            end
          end
        end
        T_C3: if (op_done) pc <= pa;
        T_C6: if (op_done) pb <= pa;
        T_D3: begin
          if (op_done) begin
            pb <= pa;
            if (dot_pos) begin
              pd   <= pc;
              pc   <= pb;
              sdir <= w0;
            end else begin
              pd   <= pb;
              sdir <= gjkis_pkg::neg_d(w0);
            end
          end
        end
        Q_D1: begin
          if (op_done && dot_pos) begin
            pd   <= pc;
            pc   <= pb;
            pb   <= pa;
            sdir <= w0;
          end
        end
        Q_D2: begin
          if (op_done && dot_pos) begin
            pb   <= pa;
            sdir <= w0;
          end
        end
        Q_D3: begin
          if (op_done && dot_pos) begin
            pc   <= pd;
            pd   <= pb;
            pb   <= pa;
            sdir <= w0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= gjkis_pkg::PH_IDLE;
      res_status <= gjkis_pkg::STAT_QUERY;
      iter       <= '0;
      max_it     <= gjkis_pkg::MAX_ITER_RESET;
      size3      <= 1'b0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        max_it <= pwdata[gjkis_pkg::IT_W-1:0];
      end
      cnt <= (op_done || !is_op) ? 3'd0 : cnt + 3'd1;
      if (put_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (func == gjkis_pkg::FUNC_START) begin
              size3      <= 1'b0;
              iter       <= '0;
              phase      <= gjkis_pkg::PH_FIRST;
              res_status <= gjkis_pkg::STAT_QUERY;
              state      <= ST_PUT;
            end else begin
              case (phase)
                gjkis_pkg::PH_IDLE: begin
                  res_status <= gjkis_pkg::STAT_IDLE_PT;
                  state      <= ST_PUT;
                end
                gjkis_pkg::PH_FIRST: begin
                  phase      <= gjkis_pkg::PH_SECOND;
                  res_status <= gjkis_pkg::STAT_QUERY;
                  state      <= ST_PUT;
                end
                gjkis_pkg::PH_SECOND: state <= S2_DOT;
                default:              state <= L_DOT;
              endcase
            end
          end
        end
        ST_PUT: if (put_load) state <= ST_IDLE;
        S2_DOT, L_DOT: begin
          if (op_done) begin
            if (dot_neg) begin
              phase      <= gjkis_pkg::PH_IDLE;
              res_status <= gjkis_pkg::STAT_SEP;
              state      <= ST_PUT;
            end else if (state == S2_DOT) begin
              state <= S2_C1;
            end else begin
              state <= size3 ? Q_F1 : T_NRM;
            end
          end
        end
        S2_C1:  if (op_done) state <= S2_C2;
        S2_C2:  if (op_done) state <= S2_FIX;
        S2_FIX: begin
          size3      <= 1'b0;
          phase      <= gjkis_pkg::PH_LOOP;
          res_status <= gjkis_pkg::STAT_QUERY;
          state      <= ST_PUT;
        end
        T_NRM: if (op_done) state <= T_C1;
        T_C1:  if (op_done) state <= T_D1;
        T_D1:  if (op_done) state <= dot_pos ? T_C2 : T_C4;
        T_C2:  if (op_done) state <= T_C3;
        T_C3: begin
          if (op_done) begin
            size3 <= 1'b0;
            state <= ST_FIN;
          end
        end
        T_C4:  if (op_done) state <= T_D2;
        T_D2:  if (op_done) state <= dot_pos ? T_C5 : T_D3;
        T_C5:  if (op_done) state <= T_C6;
        T_C6: begin
          if (op_done) begin
            size3 <= 1'b0;
            state <= ST_FIN;
          end
        end
        T_D3: begin
          if (op_done) begin
            size3 <= 1'b1;
            state <= ST_FIN;
          end
        end
        Q_F1:  if (op_done) state <= Q_D1;
        Q_D1:  if (op_done) state <= dot_pos ? ST_FIN : Q_F2;
        Q_F2:  if (op_done) state <= Q_D2;
        Q_D2:  if (op_done) state <= dot_pos ? ST_FIN : Q_F3;
        Q_F3:  if (op_done) state <= Q_D3;
        Q_D3: begin
          if (op_done) begin
            if (dot_pos) begin
              state <= ST_FIN;
            end else begin
              phase      <= gjkis_pkg::PH_IDLE;
              res_status <= gjkis_pkg::STAT_HIT;
              state      <= ST_PUT;
            end
          end
        end
        ST_FIN: begin
          // A limit of zero ends the run on the first loop point as well.
          iter <= iter_inc;
          if (iter_inc >= max_it) begin
            phase      <= gjkis_pkg::PH_IDLE;
            res_status <= gjkis_pkg::STAT_SEP;
          end else begin
            res_status <= gjkis_pkg::STAT_QUERY;
          end
          state <= ST_PUT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gjkis_chk.sv
// Port-level checker for the GJK intersection step core, bound to the top level.
`include "gjk_intersection_step_core_macros.svh"

module gjkis_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         status,
  input logic signed [gjkis_pkg::DIR_W-1:0] dir_x,
  input logic signed [gjkis_pkg::DIR_W-1:0] dir_y,
  input logic signed [gjkis_pkg::DIR_W-1:0] dir_z
);

  // A stalled result holds its value.
  `GJKIS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(dir_x) && $stable(dir_y) && $stable(dir_z))

  // Every input transfer leaves the core busy in the next cycle.
  `GJKIS_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // Only a query carries a direction.
  `GJKIS_ASSERT_IMP(a_verdict_zero_dir, out_valid && status != gjkis_pkg::STAT_QUERY, dir_x == '0 && dir_y == '0 && dir_z == '0)

endmodule

bind gjk_intersection_step_core gjkis_chk u_gjkis_chk (.*);

// File: sim/gjk_step_checker.sv
// Checker for the GJK step core: predicts each result from accepted items and compares.
module gjk_step_checker
  import gjkis_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    func,
  input  logic signed [PT_W-1:0]  pt_x,
  input  logic signed [PT_W-1:0]  pt_y,
  input  logic signed [PT_W-1:0]  pt_z,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              status,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output int                      fail_count,
  output int                      pending,
  output int                      n_hit,
  output int                      n_sep,
  output int                      n_query
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint x, y, z;
  } vec_t;

  typedef struct {
    status_t s;
    logic [DIR_W-1:0] dx, dy, dz;
  } res_t;

  typedef enum int {
    RUN_IDLE, RUN_FIRST, RUN_SECOND, RUN_LOOP
  } run_t;

  res_t expected_q[$];
  vec_t pb, pc, pd, sdir;
  int   simp3;
  run_t run;
  int   iter_cnt;
  int   iter_lim;

  function automatic vec_t mkv(longint x, longint y, longint z);
    vec_t r;
    r.x = x; r.y = y; r.z = z;
    return r;
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    return mkv(a.x - b.x, a.y - b.y, a.z - b.z);
  endfunction

  function automatic vec_t vneg(vec_t a);
    return mkv(-a.x, -a.y, -a.z);
  endfunction

  function automatic longint vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    return mkv(a.y * b.z - a.z * b.y, a.z * b.x - a.x * b.z, a.x * b.y - a.y * b.x);
  endfunction

  function automatic bit vzero(vec_t a);
    return a.x == 0 && a.y == 0 && a.z == 0;
  endfunction

  function automatic res_t mkres(status_t s, vec_t d);
    res_t r;
    r.s = s;
    r.dx = d.x[DIR_W-1:0];
    r.dy = d.y[DIR_W-1:0];
    r.dz = d.z[DIR_W-1:0];
    return r;
  endfunction

  // Triangle step: keep the feature nearest the origin.
  function automatic void triangle_step(vec_t a);
    vec_t ab, ac, ao, nrm;
    ab = vsub(pb, a); ac = vsub(pc, a); ao = vneg(a);
    nrm = vcross(ab, ac);
    simp3 = 0;
    if (vdot(vcross(ab, nrm), ao) > 0) begin
      pc = a;
      sdir = vcross(vcross(ab, ao), ab);
    end else if (vdot(vcross(nrm, ac), ao) > 0) begin
      pb = a;
      sdir = vcross(vcross(ac, ao), ac);
    end else begin
      simp3 = 1;
      if (vdot(nrm, ao) > 0) begin
        pd = pc; pc = pb; pb = a;
        sdir = nrm;
      end else begin
        pd = pb; pb = a;
        sdir = vneg(nrm);
      end
    end
  endfunction

  // Tetrahedron step: returns 1 when the origin is enclosed.
  function automatic bit tetra_step(vec_t a);
    vec_t ab, ac, ad, ao, f1, f2, f3;
    ab = vsub(pb, a); ac = vsub(pc, a); ad = vsub(pd, a); ao = vneg(a);
    f1 = vcross(ab, ac); f2 = vcross(ac, ad); f3 = vcross(ad, ab);
    simp3 = 1;
    if (vdot(f1, ao) > 0) begin
      pd = pc; pc = pb; pb = a; sdir = f1;
      return 0;
    end
    if (vdot(f2, ao) > 0) begin
      pb = a; sdir = f2;
      return 0;
    end
    if (vdot(f3, ao) > 0) begin
      pc = pd; pd = pb; pb = a; sdir = f3;
      return 0;
    end
    return 1;
  endfunction

  function automatic res_t gjk_predict(logic fn, vec_t p);
    vec_t e, z;
    z = mkv(0, 0, 0);
    if (fn == FUNC_START) begin
      sdir = p; simp3 = 0; iter_cnt = 0; run = RUN_FIRST;
      return mkres(STAT_QUERY, sdir);
    end
    case (run)
      RUN_IDLE: return mkres(STAT_IDLE_PT, z);
      RUN_FIRST: begin
        pc = p; sdir = vneg(p); run = RUN_SECOND;
        return mkres(STAT_QUERY, sdir);
      end
      RUN_SECOND: begin
        pb = p;
        if (vdot(p, sdir) < 0) begin
          run = RUN_IDLE;
          return mkres(STAT_SEP, z);
        end
        e = vsub(pc, p);
        sdir = vcross(vcross(e, vneg(p)), e);
        if (vzero(sdir)) begin
          sdir = vcross(e, mkv(1, 0, 0));
          if (vzero(sdir)) sdir = vcross(e, mkv(0, 0, -1));
        end
        simp3 = 0; run = RUN_LOOP;
        return mkres(STAT_QUERY, sdir);
      end
      default: begin
        if (vdot(p, sdir) < 0) begin
          run = RUN_IDLE;
          return mkres(STAT_SEP, z);
        end
        if (!simp3) triangle_step(p);
        else if (tetra_step(p)) begin
          run = RUN_IDLE;
          return mkres(STAT_HIT, z);
        end
        iter_cnt = (iter_cnt + 1) & 63;
        if (iter_cnt >= iter_lim) begin
          run = RUN_IDLE;
          return mkres(STAT_SEP, z);
        end
        return mkres(STAT_QUERY, sdir);
      end
    endcase
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    res_t r;
    int lim;
    if (rst) begin
      expected_q.delete();
      pb = mkv(0, 0, 0); pc = pb; pd = pb; sdir = pb;
      simp3 = 0; run = RUN_IDLE; iter_cnt = 0; iter_lim = 32;
      fail_count = 0; n_hit = 0; n_sep = 0; n_query = 0;
    end else begin
      if (psel && penable && pwrite && paddr == ADDR_W'(0)) begin
        lim = pwdata & 63;
        iter_lim = (lim == 0) ? 1 : lim;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, status", status, 0);
        end else begin
          r = expected_q.pop_front();
          if (status != r.s) report("status", status, r.s);
          if (dir_x != r.dx) report("dir_x", dir_x, r.dx);
          if (dir_y != r.dy) report("dir_y", dir_y, r.dy);
          if (dir_z != r.dz) report("dir_z", dir_z, r.dz);
          case (r.s)
            STAT_HIT: n_hit++;
            STAT_SEP: n_sep++;
            STAT_QUERY: n_query++;
            default: ;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        r = gjk_predict(func, mkv(pt_x, pt_y, pt_z));
        expected_q.push_back(r);
      end
    end
  end
endmodule

// File: sim/tb_top.sv
// Testbench top for the GJK step core: stimulus, handshake pacing and verdict.
module tb_top;
  import gjkis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_ready, func;
  logic signed [PT_W-1:0] pt_x, pt_y, pt_z;
  logic out_valid, out_ready;
  logic [1:0] status;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int fail_count, pending, n_hit, n_sep, n_query;

  int send_idle_pct, recv_idle_pct;
  bit hold_recv;
  int n_items;

  gjk_intersection_step_core dut (.*);

  gjk_step_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout waiting for the core");
    $display("Verification failed");
    $finish;
  end

  // Receiver pacing; a hold-off stalls the output for a long stretch.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid is dropped only when the sender idles or the stream pauses, so a
  // back-to-back item replaces the accepted one in the same step.
  task automatic send_item(logic fn, logic [PT_W-1:0] x, logic [PT_W-1:0] y,
                           logic [PT_W-1:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1; func <= fn;
    pt_x <= x; pt_y <= y; pt_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic cfg_write(logic [5:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_MAX_ITER) << 2; pwdata <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [PT_W-1:0] rcoord(int mag);
    return PT_W'($urandom_range(2 * mag) - mag);
  endfunction

  // One run: start, then points mostly near a random center with noise mixed in.
  task automatic random_run(int mag);
    int len, cx, cy, cz;
    len = $urandom_range(2, 14);
    cx = $urandom_range(80) - 40; cy = $urandom_range(80) - 40; cz = $urandom_range(80) - 40;
    send_item(FUNC_START, rcoord(mag), rcoord(mag), rcoord(mag));
    repeat (len) begin
      if ($urandom_range(9) == 0)
        send_item(1'b1, PT_W'($urandom), PT_W'($urandom), PT_W'($urandom));
      else
        send_item(1'b1, PT_W'(cx) + rcoord(mag), PT_W'(cy) + rcoord(mag),
                  PT_W'(cz) + rcoord(mag));
    end
  endtask

  initial begin
    logic [PT_W-1:0] mx, mn;
    int stall;
    mx = 12'h7ff; mn = 12'h800;
    rst = 1; in_valid = 0; func = 0; pt_x = 0; pt_y = 0; pt_z = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    hold_recv = 0; n_items = 0;
    send_idle_pct = 15; recv_idle_pct = 48;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: point while idle, extremes, origin on the line, enclosure.
    send_item(1'b1, 0, 0, 0);
    send_item(FUNC_START, mx, mn, mx);
    send_item(1'b1, mn, mn, mn);
    send_item(1'b1, mx, mx, mx);
    send_item(1'b1, mx, mn, 0);
    send_item(FUNC_START, 1, 0, 0);
    send_item(1'b1, 5, 0, 0);
    send_item(1'b1, -5, 0, 0);
    send_item(FUNC_START, 0, 0, 0);
    send_item(1'b1, 0, 0, 0);
    send_item(1'b1, 0, 0, 0);
    send_item(1'b1, 0, 0, 0);
    send_item(FUNC_START, 1, 1, 1);
    send_item(1'b1, 10, 10, 10);
    send_item(1'b1, -10, -10, 10);
    send_item(1'b1, 10, -10, -10);
    send_item(1'b1, -10, 10, -10);
    send_item(1'b1, 3, 3, 3);
    send_item(FUNC_START, 0, 5, 0);
    send_item(1'b1, 0, 0, 7);
    send_item(1'b1, 0, 0, -7);
    send_item(1'b1, 1, 0, 0);
    drain();

    // Long receiver hold-off while items keep arriving.
    hold_recv = 1;
    fork
      random_run(300);
      begin
        stall = 400;
        repeat (stall) @(posedge clk);
        hold_recv = 0;
      end
    join
    drain();

    cfg_write(6'd1);
    while (n_items < 450) random_run(60);
    drain();
    cfg_write(6'd63);
    send_idle_pct = 48; recv_idle_pct = 15;
    while (n_items < 1000) random_run(2047);
    drain();
    cfg_write(6'd0);
    while (n_items < 1200) random_run(30);
    drain();
    cfg_write(6'd5);
    send_idle_pct = 0; recv_idle_pct = 0;
    while (n_items < 1800) random_run($urandom_range(1) ? 50 : 2047);
    drain();

    $display("Sent %0d items over limits 32, 1, 63, 0 and 5 with varied pacing.", n_items);
    $display("Results: %0d queries, %0d separated, %0d intersecting; %0d mismatches.",
             n_query, n_sep, n_hit, fail_count);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// File: gjk_intersection_step_core.f
+incdir+rtl
rtl/gjkis_pkg.sv
rtl/gjk_intersection_step_core.sv
rtl/gjkis_chk.sv
sim/gjk_step_checker.sv
sim/tb_top.sv
